// ===== rtl/dssw_pkg.sv =====
// Shared types, constants and the segment table for the decimal display writer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dssw_pkg;

  localparam int VALUE_W = 27;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 8;
  localparam int STEP_W  = 4;

  // Default depth of the front-to-back queue (two or more)
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [VALUE_W-1:0] VALUE_MAX   = VALUE_W'(99999999);
  localparam logic [ADDR_W-1:0]  DECODE_REG  = ADDR_W'(9);
  localparam logic [DATA_W-1:0]  DECODE_MASK = 8'hfb;
  localparam logic [DATA_W-1:0]  BLANK_CODE  = DATA_W'(15);

  // Reciprocal of ten: (v * DIV10_RECIP) >> DIV10_SHIFT == v / 10 for any 32-bit v
  localparam logic [31:0] DIV10_RECIP = 32'hcccccccd;
  localparam int          DIV10_SHIFT = 35;

  // Sample handed from the front to the back
  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
  } dssw_item_t;

  // Queue fill status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } dssw_qstat_t;

  // Segment pattern of a digit with the decimal point lit
  function automatic logic [DATA_W-1:0] seg_dp(input logic [3:0] digit);
    logic [DATA_W-1:0] pat;
    case (digit)
      4'd0:    pat = 8'hfe;
      4'd1:    pat = 8'hb0;
      4'd2:    pat = 8'hed;
      4'd3:    pat = 8'hf9;
      4'd4:    pat = 8'hb3;
      4'd5:    pat = 8'hdb;
      4'd6:    pat = 8'hdf;
      4'd7:    pat = 8'hf0;
      4'd8:    pat = 8'hff;
      4'd9:    pat = 8'hfb;
      default: pat = 8'hfe;
    endcase
    return pat;
  endfunction

endpackage

// ===== rtl/dssw_front.sv =====
// Front of the display writer: takes samples, clamps them and keeps the running peak.
// Depends on dssw_pkg; pushes the value to show into dssw_queue.
`timescale 1ns / 1ps

module dssw_front import dssw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [VALUE_W-1:0] in_count_value,
  input  dssw_qstat_t        q_stat,
  output dssw_item_t         push
);

  logic [VALUE_W-1:0] held_r;
  logic [VALUE_W-1:0] held_nxt;
  logic [VALUE_W-1:0] sample;
  logic               accept;

  // Stall while the queue has no room
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  // Clamp to eight digits, then keep the larger of sample and peak
  always_comb begin
    sample   = (in_count_value > VALUE_MAX) ? VALUE_MAX : in_count_value;
    held_nxt = (sample >= held_r) ? sample : held_r;
  end

  assign push.valid = accept;
  assign push.value = held_nxt;

  // Update the peak on every accepted sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (accept) begin
      held_r <= held_nxt;
    end
  end

endmodule

// ===== rtl/dssw_queue.sv =====
// Short queue between the front and the back of the display writer.
// Depends on dssw_pkg for the item and status types.
`timescale 1ns / 1ps

module dssw_queue import dssw_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dssw_item_t         push,
  input  logic               pop,
  output dssw_qstat_t        q_stat,
  output logic [VALUE_W-1:0] head_value
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [VALUE_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign q_stat.full  = (count_r == CNT_FULL);
  assign q_stat.empty = (count_r == '0);
  assign head_value   = mem_r[rd_ptr_r];

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.value;
    end
  end

  // Advance pointers and track fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push.valid && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push.valid) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/dssw_back.sv =====
// Back of the display writer: splits a value into decimal digits and emits the
// nine driver register writes, one per cycle unless stalled. Depends on dssw_pkg.
`timescale 1ns / 1ps

module dssw_back import dssw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dssw_qstat_t        q_stat,
  input  logic [VALUE_W-1:0] head_value,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ADDR_W-1:0]  out_reg_address,
  output logic [DATA_W-1:0]  out_reg_data,
  output logic               out_last_write
);

  // Write sequence steps
  localparam logic [STEP_W-1:0] STEP_ONES     = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_TENS     = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_DECODE   = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_HUNDREDS = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_POS4     = STEP_W'(4);
  localparam logic [STEP_W-1:0] STEP_LAST     = STEP_W'(8);

  localparam int PROD_W = VALUE_W + 32;

  logic               busy_r;
  logic [STEP_W-1:0]  step_r;
  logic [VALUE_W-1:0] rem_r;
  logic [VALUE_W-1:0] rem_nxt;

  logic               out_valid_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [DATA_W-1:0]  data_r;
  logic               last_r;
  logic [ADDR_W-1:0]  addr_nxt;
  logic [DATA_W-1:0]  data_nxt;

  logic [PROD_W-1:0]  prod;
  logic [VALUE_W-1:0] quot;
  logic [VALUE_W-1:0] diff;
  logic [3:0]         digit;
  logic               emit;

  // Divide the remaining value by ten through the reciprocal
  always_comb begin
    prod  = PROD_W'(rem_r) * PROD_W'(DIV10_RECIP);
    quot  = VALUE_W'(prod >> DIV10_SHIFT);
    diff  = rem_r - ((quot << 3) + (quot << 1));
    digit = diff[3:0];
  end

  // Pick address and data of the current step
  always_comb begin
    addr_nxt = ADDR_W'(step_r);
    data_nxt = DATA_W'(digit);
    rem_nxt  = quot;
    case (step_r)
      STEP_ONES: begin
        addr_nxt = ADDR_W'(1);
      end
      STEP_TENS: begin
        addr_nxt = ADDR_W'(2);
      end
      STEP_DECODE: begin
        addr_nxt = DECODE_REG;
        data_nxt = DECODE_MASK;
        rem_nxt  = rem_r;
      end
      STEP_HUNDREDS: begin
        addr_nxt = ADDR_W'(3);
        data_nxt = seg_dp(digit);
      end
      default: begin
        // Upper positions: blank once no nonzero digits remain
        if (step_r inside {[STEP_POS4:STEP_LAST]} && rem_r == '0) begin
          data_nxt = BLANK_CODE;
        end
      end
    endcase
  end

  assign emit = busy_r && (!out_valid_r || !out_stall);
  assign pop  = !q_stat.empty && (!busy_r || (emit && step_r == STEP_LAST));

  // Sequence the writes and load the next value without a gap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= STEP_ONES;
    end else if (pop) begin
      busy_r <= 1'b1;
      step_r <= STEP_ONES;
    end else if (emit) begin
      if (step_r == STEP_LAST) begin
        busy_r <= 1'b0;
        step_r <= STEP_ONES;
      end else begin
        step_r <= step_r + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rem_r <= head_value;
    end else if (emit) begin
      rem_r <= rem_nxt;
    end
  end

  // Hold the write until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      addr_r <= addr_nxt;
      data_r <= data_nxt;
      last_r <= (step_r == STEP_LAST);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_reg_address = addr_r;
  assign out_reg_data    = data_r;
  assign out_last_write  = last_r;

endmodule

// ===== rtl/decimal_seven_segment_writer.sv =====
// Decimal seven-segment writer: counter sample in, nine display driver writes out.
// Sample channel: in_valid / in_stall with in_count_value (27 bits, clamped to 99999999).
// Write channel: out_valid / out_stall with out_reg_address, out_reg_data and
// out_last_write, which marks the ninth write of a sample.
// The block shows the largest sample seen so far: a smaller sample repeats the peak.
// Each sample yields writes to positions 1 and 2 (digit codes), the decode register
// (0xfb), position 3 (segment pattern with decimal point) and positions 4 to 8
// (digit codes, blank code 15 above the highest nonzero digit).
// A sample passes the queue, the back end's remainder register and the output
// register before its first write is valid. The back end's digit sequencer
// drives one output register, one write per cycle while out_stall is low, and peels
// a decimal digit per digit write through a multiply by the reciprocal of ten.
// A queue of QUEUE_DEPTH samples sits between the sample front end and the write
// back end; in_stall rises only when that queue is full.
// When out_stall is high, the current write holds and the sequencer waits.
// Synchronous reset clears the peak to zero and empties the queue and output.
// Depends on dssw_pkg, dssw_front, dssw_queue and dssw_back.
`timescale 1ns / 1ps

module decimal_seven_segment_writer import dssw_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [VALUE_W-1:0] in_count_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ADDR_W-1:0]  out_reg_address,
  output logic [DATA_W-1:0]  out_reg_data,
  output logic               out_last_write
);

  dssw_item_t         push;
  dssw_qstat_t        q_stat;
  logic [VALUE_W-1:0] head_value;
  logic               pop;

  // Accept and clamp samples, track the peak
  dssw_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_count_value (in_count_value),
    .q_stat         (q_stat),
    .push           (push)
  );

  // Buffer values to show
  dssw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (pop),
    .q_stat     (q_stat),
    .head_value (head_value)
  );

  // Split into digits and emit the writes
  dssw_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .head_value      (head_value),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_reg_address (out_reg_address),
    .out_reg_data    (out_reg_data),
    .out_last_write  (out_last_write)
  );

  // The ninth write always goes to position 8
  a_last_is_pos8: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_write |-> out_reg_address == ADDR_W'(8))
    else $error("last write not at position 8");

  // The decode register only ever gets the decode mask
  a_decode_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reg_address == DECODE_REG |-> out_reg_data == DECODE_MASK)
    else $error("decode register written with wrong mask");

  // Position 3 always carries a lit decimal point
  a_pos3_dp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reg_address == ADDR_W'(3) |-> out_reg_data[7])
    else $error("position 3 without decimal point");

  // No pop from an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule
